/* sv/gradient_magnitude_2d_unit_macros.svh */
// ----------------------------------------------------------------------------
// Gradient magnitude unit assertion macros
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_MAGNITUDE_2D_UNIT_MACROS_SVH
`define GRADIENT_MAGNITUDE_2D_UNIT_MACROS_SVH
`ifndef SYNTH
`define GM2D_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define GM2D_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define GM2D_ASSERT_IMP(lbl, ante, cons, msg)
`define GM2D_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* sv/gm2d_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient magnitude package
// Widths, register indexes, control types and the sequencer states.
// ----------------------------------------------------------------------------
package gm2d_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int PIX_W     = 16;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int WID_W     = COL_W + 1;
   localparam int MEM_W     = 2 * PIX_W;
   localparam int SCALE_W   = 16;
   localparam int FRAC_W    = 8;
   localparam int PRD_W     = PIX_W + SCALE_W;
   localparam int GRD_W     = PRD_W - FRAC_W;
   localparam int SQ_W      = 2 * GRD_W;
   localparam int MAG_W     = 25;
   localparam int SUM_W     = 2 * MAG_W;
   localparam int ROWS_W    = 2;

   localparam int IW_REG_W  = 11;
   localparam int AX_REG_W  = 2;
   localparam int ADDR_W    = 4;
   localparam int DATA_W    = 32;

   localparam logic [1:0] REG_IMAGE_WIDTH = 2'd0;
   localparam logic [1:0] REG_AXIS_COUNT  = 2'd1;
   localparam logic [1:0] REG_X_SCALE     = 2'd2;
   localparam logic [1:0] REG_Y_SCALE     = 2'd3;

   typedef struct packed {
      logic [IW_REG_W-1:0] image_width;
      logic [AX_REG_W-1:0] axis_count;
      logic [SCALE_W-1:0]  x_scale;
      logic [SCALE_W-1:0]  y_scale;
   } cfg_type;

   typedef struct packed {
      logic             rd_en;
      logic [COL_W-1:0] rd_addr;
      logic             wr_en;
      logic [COL_W-1:0] wr_addr;
      logic [MEM_W-1:0] wr_data;
   } mem_req_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD2,
      S_RD3,
      S_SQ,
      S_SUM,
      S_ROOT,
      S_OUT
   } state_type;

endpackage

/* sv/gm2d_csr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient magnitude configuration registers
// APB register file holding width, axis count and the two axis scales.
// ----------------------------------------------------------------------------
module gm2d_csr (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [gm2d_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [gm2d_pkg::DATA_W-1:0] csr_pwdata,
   output logic [gm2d_pkg::DATA_W-1:0] csr_prdata,
   output logic                      csr_pready,
   output gm2d_pkg::cfg_type         cfg
);
   import gm2d_pkg::*;

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width <= IW_REG_W'(MAX_WIDTH);
         cfg_ff.axis_count  <= AX_REG_W'(2);
         cfg_ff.x_scale     <= SCALE_W'(256);
         cfg_ff.y_scale     <= SCALE_W'(256);
      end else if (wr_en) begin
         case (reg_idx)
            REG_IMAGE_WIDTH: cfg_ff.image_width <= csr_pwdata[IW_REG_W-1:0];
            REG_AXIS_COUNT:  cfg_ff.axis_count  <= csr_pwdata[AX_REG_W-1:0];
            REG_X_SCALE:     cfg_ff.x_scale     <= csr_pwdata[SCALE_W-1:0];
            REG_Y_SCALE:     cfg_ff.y_scale     <= csr_pwdata[SCALE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_IMAGE_WIDTH: csr_prdata = DATA_W'(cfg_ff.image_width);
         REG_AXIS_COUNT:  csr_prdata = DATA_W'(cfg_ff.axis_count);
         REG_X_SCALE:     csr_prdata = DATA_W'(cfg_ff.x_scale);
         REG_Y_SCALE:     csr_prdata = DATA_W'(cfg_ff.y_scale);
         default:         csr_prdata = '0;
      endcase
   end

endmodule

/* sv/gm2d_row_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient magnitude row memory
// One word per column: older row sample in the upper half, previous row
// sample in the lower half. One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gm2d_row_mem (
   input  logic                       clock,
   input  gm2d_pkg::mem_req_type      mem_req,
   output logic [gm2d_pkg::MEM_W-1:0] rd_data
);
   import gm2d_pkg::*;

   logic [MEM_W-1:0] mem [MAX_WIDTH];
   logic [MEM_W-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

endmodule

/* sv/gm2d_isqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient magnitude square root
// Iterative floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module gm2d_isqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [gm2d_pkg::SUM_W-1:0] operand,
   output logic                       done,
   output logic [gm2d_pkg::MAG_W-1:0] root
);
   import gm2d_pkg::*;

   logic [SUM_W-1:0] rem_ff;
   logic [SUM_W-1:0] res_ff;
   logic [SUM_W-1:0] bit_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [SUM_W-1:0] trial;

   assign trial = res_ff + bit_ff;
   assign done  = done_ff;
   assign root  = res_ff[MAG_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && bit_ff[0]) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= operand;
         res_ff <= '0;
         bit_ff <= SUM_W'(1) << (SUM_W - 2);
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_ff <= rem_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

endmodule

/* sv/gradient_magnitude_2d_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient magnitude unit
// Central-difference gradient magnitude over a raster pixel stream, output
// one row behind, with the two stored rows held in one row memory.
// ----------------------------------------------------------------------------
//  Channel   Ports                                   Beat
//  req       req_valid req_ready req_pixel req_drain one pixel or drain item
//  rsp       rsp_valid rsp_ready rsp_magnitude ...   one magnitude
//  csr       APB csr_psel ... csr_pready             one register write/read
//
// An item with a result goes from acceptance to the result register through
// two memory reads, a state that registers the products, a square stage, the
// sum, the iterations of the square root unit, a state that sees the root and
// one that loads it. The next item can be accepted in the cycle after the load.
// A first-row item returns to idle once its products are registered.
// The row memory needs no clearing after reset; the block is ready at once.
// The result register lets the next item be accepted while a beat waits.
// ----------------------------------------------------------------------------
`include "gradient_magnitude_2d_unit_macros.svh"

module gradient_magnitude_2d_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [15:0]                  req_pixel,
   input  logic                         req_drain,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [24:0]                  rsp_magnitude,
   output logic                         rsp_last_in_frame,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [gm2d_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [gm2d_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [gm2d_pkg::DATA_W-1:0]  csr_prdata,
   output logic                         csr_pready
);
   import gm2d_pkg::*;

   cfg_type          cfg;
   mem_req_type      mem_req;
   logic [MEM_W-1:0] rd_data;

   state_type        state_ff;
   state_type        state_in;

   logic [PIX_W-1:0] pix_ff;
   logic             drain_ff;
   logic [COL_W-1:0] col_ff;
   logic             last_ff;
   logic [PIX_W-1:0] centre_ff;
   logic [PIX_W-1:0] up_ff;
   logic [PIX_W-1:0] left_ff;
   logic [COL_W-1:0] column_ff;
   logic [ROWS_W-1:0] rows_seen_ff;
   logic [PRD_W-1:0] prod_x_ff;
   logic [PRD_W-1:0] prod_y_ff;
   logic             end_frame_ff;
   logic [SQ_W-1:0]  sq_x_ff;
   logic [SQ_W-1:0]  sq_y_ff;
   logic             rsp_valid_ff;
   logic [MAG_W-1:0] rsp_mag_ff;
   logic             rsp_last_ff;

   logic             accept;
   logic             step;
   logic             sq_start;
   logic             sq_done;
   logic [MAG_W-1:0] root;
   logic             rsp_load;
   logic [WID_W-1:0] w_eff;
   logic [WID_W-1:0] col_plus1;
   logic             last_now;
   logic [PIX_W-1:0] left_v;
   logic [PIX_W-1:0] right_v;
   logic [PIX_W-1:0] up_v;
   logic [PIX_W-1:0] down_v;
   logic [PIX_W-1:0] dx;
   logic [PIX_W-1:0] dy;
   logic [GRD_W-1:0] gx;
   logic [GRD_W-1:0] gy;
   logic             two_axes;
   logic [SUM_W-1:0] sum_sq;

   gm2d_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   gm2d_row_mem u_row_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   gm2d_isqrt u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sq_start),
      .operand (sum_sq),
      .done    (sq_done),
      .root    (root)
   );

   always_comb begin
      if (cfg.image_width == '0) begin
         w_eff = WID_W'(1);
      end else if (WID_W'(cfg.image_width) > WID_W'(MAX_WIDTH)) begin
         w_eff = WID_W'(MAX_WIDTH);
      end else begin
         w_eff = WID_W'(cfg.image_width);
      end
   end

   assign col_plus1 = {1'b0, column_ff} + WID_W'(1);
   assign last_now  = col_plus1 >= w_eff;
   assign two_axes  = cfg.axis_count >= AX_REG_W'(2);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in         = state_ff;
      req_ready        = 1'b0;
      accept           = 1'b0;
      step             = 1'b0;
      sq_start         = 1'b0;
      rsp_load         = 1'b0;
      mem_req.rd_en    = 1'b0;
      mem_req.rd_addr  = column_ff;
      mem_req.wr_en    = 1'b0;
      mem_req.wr_addr  = col_ff;
      mem_req.wr_data  = {rd_data[PIX_W-1:0],
                          drain_ff ? rd_data[PIX_W-1:0] : pix_ff};
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               accept        = 1'b1;
               mem_req.rd_en = 1'b1;
               state_in      = S_RD2;
            end
         end
         S_RD2: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = col_ff + COL_W'(1);
            mem_req.wr_en   = 1'b1;
            state_in        = S_RD3;
         end
         S_RD3: begin
            step     = 1'b1;
            state_in = (rows_seen_ff != '0) ? S_SQ : S_IDLE;
         end
         S_SQ: begin
            state_in = S_SUM;
         end
         S_SUM: begin
            sq_start = 1'b1;
            state_in = S_ROOT;
         end
         S_ROOT: begin
            if (sq_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff   <= req_pixel[PIX_W-1:0];
         drain_ff <= req_drain;
         col_ff   <= column_ff;
         last_ff  <= last_now;
      end
      if (state_ff == S_RD2) begin
         centre_ff <= rd_data[PIX_W-1:0];
         up_ff     <= rd_data[MEM_W-1:PIX_W];
      end
   end

   assign left_v  = (col_ff == '0) ? centre_ff : left_ff;
   assign right_v = last_ff ? centre_ff : rd_data[PIX_W-1:0];
   assign up_v    = (rows_seen_ff >= ROWS_W'(2)) ? up_ff : centre_ff;
   assign down_v  = drain_ff ? centre_ff : pix_ff;
   assign dx      = (left_v >= right_v) ? left_v - right_v : right_v - left_v;
   assign dy      = (up_v >= down_v) ? up_v - down_v : down_v - up_v;

   always_ff @(posedge clock) begin
      if (step) begin
         left_ff      <= centre_ff;
         prod_x_ff    <= dx * cfg.x_scale;
         prod_y_ff    <= two_axes ? dy * cfg.y_scale : '0;
         end_frame_ff <= drain_ff && last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         rows_seen_ff <= '0;
      end else if (step) begin
         if (last_ff) begin
            column_ff <= '0;
            if (drain_ff) begin
               rows_seen_ff <= '0;
            end else if (rows_seen_ff < ROWS_W'(2)) begin
               rows_seen_ff <= rows_seen_ff + ROWS_W'(1);
            end
         end else begin
            column_ff <= col_ff + COL_W'(1);
         end
      end
   end

   assign gx = prod_x_ff[PRD_W-1:FRAC_W];
   assign gy = prod_y_ff[PRD_W-1:FRAC_W];

   always_ff @(posedge clock) begin
      if (state_ff == S_SQ) begin
         sq_x_ff <= gx * gx;
         sq_y_ff <= gy * gy;
      end
   end

   assign sum_sq = SUM_W'(sq_x_ff) + SUM_W'(sq_y_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_mag_ff  <= root;
         rsp_last_ff <= end_frame_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_magnitude     = rsp_mag_ff;
   assign rsp_last_in_frame = rsp_last_ff;

   `GM2D_ASSERT_IMP(a_mem_distinct_entries, mem_req.rd_en && mem_req.wr_en,
      mem_req.rd_addr != mem_req.wr_addr, "Row memory read and write hit the same entry.")
   `GM2D_ASSERT_IMP(a_root_done_in_wait, sq_done, state_ff == S_ROOT,
      "Square root finished outside its wait state.")
   `GM2D_ASSERT_NXT(a_row_end_wraps, step && last_ff, column_ff == '0,
      "Column did not wrap at the end of a row.")
   `GM2D_ASSERT_NXT(a_frame_end_clears, step && last_ff && drain_ff, rows_seen_ff == '0,
      "Row count not cleared at the end of the frame.")

endmodule

/* dv/gradient_magnitude_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient magnitude result checker
// Watches the pixel, magnitude and register channels of the gradient unit.
// It keeps its own copy of both line stores and the register settings. It
// predicts the magnitude and end-of-frame flag of each beat accepted after a
// frame's first row and compares every result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module gradient_magnitude_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [15:0]                 req_pixel,
   input  logic                        req_drain,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [24:0]                 rsp_magnitude,
   input  logic                        rsp_last_in_frame,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [gm2d_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [gm2d_pkg::DATA_W-1:0] csr_pwdata,
   input  logic                        csr_pready,
   output int                          mismatch_count,
   output int                          pending_count
);
   import gm2d_pkg::*;

   typedef struct packed {
      logic [MAG_W-1:0] magnitude;
      logic             last_in_frame;
   } magnitude_beat_type;

   magnitude_beat_type magnitude_queue [$];
   logic [PIX_W-1:0]   row_above [MAX_WIDTH];
   logic [PIX_W-1:0]   row_two_above [MAX_WIDTH];
   int                 next_column;
   int                 full_rows;
   cfg_type            cfg;

   function automatic logic [MAG_W-1:0] floor_sqrt(input logic [63:0] value);
      logic [MAG_W-1:0] root;
      logic [MAG_W-1:0] trial;
      root = '0;
      for (int b = MAG_W - 1; b >= 0; b--) begin
         trial = root | (MAG_W'(1) << b);
         if (64'(trial) * 64'(trial) <= value) begin
            root = trial;
         end
      end
      return root;
   endfunction

   function automatic logic [GRD_W-1:0] axis_gradient(input logic [PIX_W-1:0] a,
                                                      input logic [PIX_W-1:0] b,
                                                      input logic [SCALE_W-1:0] scale);
      logic [PIX_W-1:0] diff;
      logic [PRD_W-1:0] product;
      diff = (a >= b) ? a - b : b - a;
      product = diff * scale;
      return product[PRD_W-1:FRAC_W];
   endfunction

   task automatic flag_mismatch(input string what, input longint seen, input longint predicted);
      $display("ERROR at %0t: %s: saw %0d, predicted %0d", $time, what, seen, predicted);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : observe
      magnitude_beat_type want;
      int                 w;
      int                 c;
      logic               ends_row;
      logic [PIX_W-1:0]   centre;
      logic [PIX_W-1:0]   west;
      logic [PIX_W-1:0]   east;
      logic [PIX_W-1:0]   north;
      logic [PIX_W-1:0]   south;
      logic [GRD_W-1:0]   gx;
      logic [GRD_W-1:0]   gy;
      logic [63:0]        energy;
      if (reset) begin
         magnitude_queue.delete();
         next_column = 0;
         full_rows = 0;
         mismatch_count = 0;
         cfg.image_width = IW_REG_W'(MAX_WIDTH);
         cfg.axis_count = AX_REG_W'(2);
         cfg.x_scale = SCALE_W'(256);
         cfg.y_scale = SCALE_W'(256);
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_IMAGE_WIDTH: cfg.image_width = csr_pwdata[IW_REG_W-1:0];
               REG_AXIS_COUNT:  cfg.axis_count = csr_pwdata[AX_REG_W-1:0];
               REG_X_SCALE:     cfg.x_scale = csr_pwdata[SCALE_W-1:0];
               REG_Y_SCALE:     cfg.y_scale = csr_pwdata[SCALE_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (magnitude_queue.size() == 0) begin
               flag_mismatch("magnitude beat with none predicted", rsp_magnitude, -1);
            end else begin
               want = magnitude_queue.pop_front();
               if (rsp_magnitude !== want.magnitude) begin
                  flag_mismatch("magnitude", rsp_magnitude, want.magnitude);
               end
               if (rsp_last_in_frame !== want.last_in_frame) begin
                  flag_mismatch("last_in_frame", rsp_last_in_frame, want.last_in_frame);
               end
            end
         end
         if (req_valid && req_ready) begin
            w = cfg.image_width;
            if (w < 1) w = 1;
            if (w > MAX_WIDTH) w = MAX_WIDTH;
            c = (next_column >= MAX_WIDTH) ? MAX_WIDTH - 1 : next_column;
            ends_row = (c + 1 >= w);
            if (full_rows != 0) begin
               centre = row_above[c];
               west = (c > 0) ? row_two_above[c-1] : centre;
               east = (c + 1 < w) ? row_above[c+1] : centre;
               gx = axis_gradient(west, east, cfg.x_scale);
               energy = 64'(gx) * 64'(gx);
               if (cfg.axis_count >= 2) begin
                  north = (full_rows >= 2) ? row_two_above[c] : centre;
                  south = req_drain ? centre : req_pixel;
                  gy = axis_gradient(north, south, cfg.y_scale);
                  energy += 64'(gy) * 64'(gy);
               end
               want.magnitude = floor_sqrt(energy);
               want.last_in_frame = req_drain && ends_row;
               magnitude_queue.push_back(want);
            end
            row_two_above[c] = row_above[c];
            if (!req_drain) begin
               row_above[c] = req_pixel;
            end
            if (ends_row) begin
               next_column = 0;
               if (req_drain) begin
                  full_rows = 0;
               end else if (full_rows < 2) begin
                  full_rows++;
               end
            end else begin
               next_column = c + 1;
            end
         end
      end
      pending_count = magnitude_queue.size();
   end

endmodule

/* dv/tb_gradient_magnitude_2d_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient magnitude unit testbench
// Drives whole frames of pixel rows followed by a row of drain beats through
// the unit under several register settings, with random gaps and stalls on
// both channels and one long result stall. A separate checker predicts and
// compares every magnitude; this module makes the stimulus and the verdict.
// ----------------------------------------------------------------------------
module tb_gradient_magnitude_2d_unit;
   import gm2d_pkg::*;

   localparam int STALL_LIMIT   = 2000;
   localparam int HOLD_CYCLES   = 200;
   localparam int SETTLE_CYCLES = 40;
   localparam int ITEM_TARGET   = 350;
   localparam int MAX_GAP       = 16;

   // Three rows of width three that drive both gradients to full scale.
   localparam logic [8:0][15:0] EDGE_PIXELS = {16'h0000, 16'hFFFF, 16'h0000,
                                               16'hFFFF, 16'h0000, 16'h0000,
                                               16'h0000, 16'h0000, 16'hFFFF};

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [15:0]       req_pixel;
   logic              req_drain;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [24:0]       rsp_magnitude;
   logic              rsp_last_in_frame;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [DATA_W-1:0] csr_pwdata;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;

   int mismatch_count;
   int pending_count;
   int quiet_cycles;
   int width_reg;
   int col_pos;
   int rows_held;
   int filled_w;
   int items_sent;
   bit req_idle_en;
   bit rsp_idle_en;
   bit hold_off_req;

   gradient_magnitude_2d_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_pixel         (req_pixel),
      .req_drain         (req_drain),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_magnitude     (rsp_magnitude),
      .rsp_last_in_frame (rsp_last_in_frame),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   gradient_magnitude_checker magnitude_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_pixel         (req_pixel),
      .req_drain         (req_drain),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_magnitude     (rsp_magnitude),
      .rsp_last_in_frame (rsp_last_in_frame),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_pready        (csr_pready),
      .mismatch_count    (mismatch_count),
      .pending_count     (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   function automatic int eff_width();
      if (width_reg < 1) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
   endfunction

   function automatic int pick_scale();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 65535;
         2: return 256;
         default: return $urandom_range(0, 65535);
      endcase
   endfunction

   task automatic write_reg(input logic [1:0] index, input logic [DATA_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(input int width_value, input int axes, input int xs, input int ys);
      write_reg(REG_IMAGE_WIDTH, width_value);
      write_reg(REG_AXIS_COUNT, axes);
      write_reg(REG_X_SCALE, xs);
      write_reg(REG_Y_SCALE, ys);
      width_reg = width_value & 'h7FF;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic push_item(input logic [15:0] pixel, input logic drain);
      int gap;
      int c;
      gap = req_idle_en ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= pixel;
      req_drain <= drain;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      c = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;
      if (!drain && c == filled_w) filled_w++;
      if (c + 1 >= eff_width()) begin
         col_pos = 0;
         if (drain) begin
            rows_held = 0;
         end else if (rows_held < 2) begin
            rows_held++;
         end
      end else begin
         col_pos = c + 1;
      end
      items_sent++;
   endtask

   // Drain beats are only placed where every stored entry of the row has
   // been written, so the unit never reads an unwritten line store entry.
   task automatic send_row(input int style, input int drain_pct);
      int          w;
      logic [15:0] base;
      logic [15:0] p;
      logic        d;
      w = eff_width();
      if (rows_held == 0 && filled_w < w) drain_pct = 0;
      base = 16'($urandom);
      for (int c = 0; c < w; c++) begin
         d = ($urandom_range(0, 99) < drain_pct);
         case (style)
            0: p = 16'($urandom);
            1: p = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            2: p = base + 16'($urandom_range(0, 7));
            default: p = base + 16'(c * 97);
         endcase
         if (d) p = 16'($urandom);
         push_item(p, d);
      end
   endtask

   initial begin : result_sink
      int hold;
      rsp_ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (hold_off_req) begin
            hold = HOLD_CYCLES;
            hold_off_req = 1'b0;
         end else begin
            hold = rsp_idle_en ? $urandom_range(0, MAX_GAP) : 0;
         end
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int phase;
      int width_pick;
      int budget;
      reset = 1'b1;
      req_valid = 1'b0;
      req_pixel = '0;
      req_drain = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      width_reg = MAX_WIDTH;
      col_pos = 0;
      rows_held = 0;
      filled_w = 0;
      items_sent = 0;
      req_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
      hold_off_req = 1'b0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      configure(3, 2, 65535, 65535);
      for (int i = 0; i < 9; i++) push_item(EDGE_PIXELS[i], 1'b0);
      send_row(0, 100);

      // A row is cut short by narrowing the image while the unit is idle.
      wait_idle();
      configure(4, 2, 0, 300);
      repeat (6) push_item(16'($urandom), 1'b0);
      wait_idle();
      write_reg(REG_IMAGE_WIDTH, 2);
      width_reg = 2;
      push_item(16'($urandom), 1'b0);
      send_row(0, 100);
      send_row(0, 100);

      phase = 0;
      while (items_sent < ITEM_TARGET || phase < 2) begin
         case ($urandom_range(0, 9))
            0: width_pick = 0;
            1: width_pick = 1;
            2: width_pick = 2;
            3, 4, 5, 6: width_pick = $urandom_range(3, 8);
            default: width_pick = $urandom_range(9, 40);
         endcase
         if (phase == 1) width_pick = 16;
         wait_idle();
         configure(width_pick, $urandom_range(0, 3), pick_scale(), pick_scale());
         req_idle_en = ($urandom_range(0, 3) != 0);
         rsp_idle_en = ($urandom_range(0, 3) != 0);
         if (phase == 1) begin
            rsp_idle_en = 1'b1;
            hold_off_req = 1'b1;
         end
         budget = items_sent + $urandom_range(40, 120);
         while (items_sent < budget) begin
            if (rows_held == 0 && filled_w >= eff_width() && $urandom_range(0, 9) == 0) begin
               send_row(0, 100);
            end
            repeat ($urandom_range(1, 4)) begin
               send_row($urandom_range(0, 3), ($urandom_range(0, 7) == 0) ? 20 : 0);
            end
            if (rows_held != 0) send_row($urandom_range(0, 3), 100);
         end
         phase++;
      end

      // One row at the widest setting, with an out-of-range width value,
      // then a single drain beat at width one closes the frame.
      wait_idle();
      configure(2047, 3, 65535, 65535);
      req_idle_en = 1'b0;
      rsp_idle_en = 1'b0;
      send_row(1, 0);
      wait_idle();
      write_reg(REG_IMAGE_WIDTH, 1);
      width_reg = 1;
      send_row(0, 100);

      wait_idle();
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+sv
sv/gm2d_pkg.sv
sv/gm2d_csr.sv
sv/gm2d_row_mem.sv
sv/gm2d_isqrt.sv
sv/gradient_magnitude_2d_unit.sv
dv/gradient_magnitude_checker.sv
dv/tb_gradient_magnitude_2d_unit.sv
